### src/harmonic_bond_force_unit_macros.svh
// assertion macros shared by the bond force unit
// no dependencies; taken in by the top level with an include
`ifndef HARMONIC_BOND_FORCE_UNIT_MACROS_SVH
`define HARMONIC_BOND_FORCE_UNIT_MACROS_SVH

// cond at an edge implies expr at the same edge
`define HBF_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("hbf assertion failed");

// cond never holds outside reset
`define HBF_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hbf forbidden condition");

`endif

### src/hbf_pkg.sv
// shared widths, register indexes, stage payload structs and saturation helpers
// of the bond force unit; no dependencies
`default_nettype none
package hbf_pkg;

    localparam int COORD_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CW          = COORD_BITS;
    localparam int SQW         = 2 * CW;
    localparam int PW          = 3 * CW;
    localparam int YW          = PW - FRAC_BITS;
    localparam int SQRT_STAGES = CW;
    localparam int DIV_STAGES  = CW;
    localparam int LATENCY     = 4 + SQRT_STAGES + 3 + DIV_STAGES + 3;
    localparam int IDXW        = 3;

    typedef enum logic [IDXW-1:0] {
        REG_PERIODIC = 3'd0,
        REG_THREE_D  = 3'd1,
        REG_BOX_X    = 3'd2,
        REG_BOX_Y    = 3'd3,
        REG_BOX_Z    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][CW-1:0] d;
        logic [CW-2:0]      k;
        logic [CW-2:0]      l0;
    } t_geo;

    typedef struct packed {
        logic [2:0][CW-1:0] d;
        logic [CW-1:0]      len;
        logic               eneg;
        logic [2:0]         ovf;
    } t_div;

    // magnitude of a two's complement value, most negative fits unsigned
    function automatic logic [CW-1:0] f_mag(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    // saturate a magnitude with sign to a two's complement pattern
    function automatic logic [CW-1:0] f_pack(input logic ovf, input logic [CW-1:0] mag,
                                             input logic neg);
        logic [CW-1:0] cap;
        logic [CW-1:0] v;
        cap = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        v   = (ovf || mag > cap) ? cap : mag;
        return neg ? (~v + 1'b1) : v;
    endfunction

endpackage
`default_nettype wire

### src/hbf_front.sv
// front stages: separation, minimum image wrap, saturation, squares and their sum
// depends on hbf_pkg
`default_nettype none
module hbf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [2:0][hbf_pkg::CW-1:0]     i_head,
    input  logic [2:0][hbf_pkg::CW-1:0]     i_tail,
    input  logic [hbf_pkg::CW-2:0]          i_k,
    input  logic [hbf_pkg::CW-2:0]          i_l0,
    input  logic                            i_periodic,
    input  logic                            i_three_d,
    input  logic [2:0][hbf_pkg::CW-2:0]     i_box,
    output logic                            o_vld,
    output hbf_pkg::t_geo                   o_geo,
    output logic [hbf_pkg::SQW-1:0]         o_sum
);
    import hbf_pkg::*;

    logic                     r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic [2:0][CW:0]         r_a_diff;
    logic [CW-2:0]            r_a_k, r_a_l0;
    t_geo                     r_b_geo, r_c_geo, r_d_geo;
    logic [2:0][SQW-1:0]      r_c_sq;
    logic [SQW-1:0]           r_d_sum;
    logic [2:0][CW:0]         n_diff;
    logic [2:0][CW-1:0]       n_d;
    logic [2:0][SQW-1:0]      n_sq;
    logic [SQW+1:0]           n_sum;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_diff[a] = {i_head[a][CW-1], i_head[a]} - {i_tail[a][CW-1], i_tail[a]};
        end
    end

    always_comb begin
        logic signed [CW+2:0] w;
        logic signed [CW+2:0] b;
        logic signed [CW+2:0] tw;
        for (int a = 0; a < 3; a++) begin
            w  = (CW+3)'($signed(r_a_diff[a]));
            b  = $signed({4'b0000, i_box[a]});
            tw = w <<< 1;
            if (i_periodic) begin
                if (tw > b) begin
                    w = w - b;
                end else if (tw < -b) begin
                    w = w + b;
                end
                if (a == 2 && !i_three_d) begin
                    w = '0;
                end
            end
            if (w > $signed((CW+3)'({1'b0, {(CW-1){1'b1}}}))) begin
                n_d[a] = {1'b0, {(CW-1){1'b1}}};
            end else if (w < -$signed((CW+3)'({1'b1, {(CW-1){1'b0}}}))) begin
                n_d[a] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_d[a] = w[CW-1:0];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sq[a] = SQW'(f_mag(r_b_geo.d[a])) * SQW'(f_mag(r_b_geo.d[a]));
        end
        n_sum = (SQW+2)'(r_c_sq[0]) + (SQW+2)'(r_c_sq[1]) + (SQW+2)'(r_c_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
        r_a_diff   <= n_diff;
        r_a_k      <= i_k;
        r_a_l0     <= i_l0;
        r_b_geo.d  <= n_d;
        r_b_geo.k  <= r_a_k;
        r_b_geo.l0 <= r_a_l0;
        r_c_sq     <= n_sq;
        r_c_geo    <= r_b_geo;
        // three squares of at most 2^(2c-2) never carry past 2c bits
        r_d_sum    <= n_sum[SQW-1:0];
        r_d_geo    <= r_c_geo;
    end

    assign o_vld = r_d_vld;
    assign o_geo = r_d_geo;
    assign o_sum = r_d_sum;

endmodule
`default_nettype wire

### src/hbf_sqrt.sv
// pipelined integer square root, one root bit per stage, geometry rides along
// depends on hbf_pkg
`default_nettype none
module hbf_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  hbf_pkg::t_geo            i_geo,
    input  logic [hbf_pkg::SQW-1:0]  i_sum,
    output logic                     o_vld,
    output hbf_pkg::t_geo            o_geo,
    output logic [hbf_pkg::CW-1:0]   o_len
);
    import hbf_pkg::*;

    logic              r_vld  [SQRT_STAGES];
    t_geo              r_geo  [SQRT_STAGES];
    logic [CW+1:0]     r_rem  [SQRT_STAGES];
    logic [CW-1:0]     r_root [SQRT_STAGES];
    logic [SQW-1:0]    r_num  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic           p_vld;
        t_geo           p_geo;
        logic [CW+1:0]  p_rem;
        logic [CW-1:0]  p_root;
        logic [SQW-1:0] p_num;
        logic [CW+1:0]  part;
        logic [CW+1:0]  trial;
        logic [CW+1:0]  n_rem;
        logic [CW-1:0]  n_root;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_geo  = i_geo;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_num  = i_sum;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_geo  = r_geo[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_num  = r_num[s-1];
        end

        // remainder stays below 2^(s+1), root below 2^s
        always_comb begin
            part  = {p_rem[CW-1:0], p_num[SQW-1 -: 2]};
            trial = {p_root, 2'b01};
            if (part >= trial) begin
                n_rem  = part - trial;
                n_root = {p_root[CW-2:0], 1'b1};
            end else begin
                n_rem  = part;
                n_root = {p_root[CW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
            r_geo[s]  <= p_geo;
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_num[s]  <= {p_num[SQW-3:0], 2'b00};
        end
    end

    assign o_vld = r_vld[SQRT_STAGES-1];
    assign o_geo = r_geo[SQRT_STAGES-1];
    assign o_len = r_root[SQRT_STAGES-1];

endmodule
`default_nettype wire

### src/hbf_div.sv
// three lane pipelined restoring divider by the bond length, one quotient bit per stage
// depends on hbf_pkg
`default_nettype none
module hbf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  hbf_pkg::t_div                i_meta,
    input  logic [2:0][hbf_pkg::CW-1:0]  i_rem,
    input  logic [2:0][hbf_pkg::CW-1:0]  i_num,
    output logic                         o_vld,
    output hbf_pkg::t_div                o_meta,
    output logic [2:0][hbf_pkg::CW-1:0]  o_quo
);
    import hbf_pkg::*;

    logic                r_vld  [DIV_STAGES];
    t_div                r_meta [DIV_STAGES];
    logic [2:0][CW-1:0]  r_rem  [DIV_STAGES];
    logic [2:0][CW-1:0]  r_quo  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic               p_vld;
        t_div               p_meta;
        logic [2:0][CW-1:0] p_rem;
        logic [2:0][CW-1:0] p_quo;
        logic [2:0][CW-1:0] n_rem;
        logic [2:0][CW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_meta = i_meta;
            assign p_rem  = i_rem;
            assign p_quo  = i_num;
        end else begin : g_next
            assign p_vld  = r_vld[s-1];
            assign p_meta = r_meta[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_quo  = r_quo[s-1];
        end

        // dividend bits leave the top of quo while quotient bits enter below
        always_comb begin
            logic [CW:0] part;
            logic [CW:0] dsr;
            for (int l = 0; l < 3; l++) begin
                part = {p_rem[l], p_quo[l][CW-1]};
                dsr  = {1'b0, p_meta.len};
                if (part >= dsr) begin
                    part     = part - dsr;
                    n_quo[l] = {p_quo[l][CW-2:0], 1'b1};
                end else begin
                    n_quo[l] = {p_quo[l][CW-2:0], 1'b0};
                end
                n_rem[l] = part[CW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
            r_meta[s] <= p_meta;
            r_rem[s]  <= n_rem;
            r_quo[s]  <= n_quo;
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_meta = r_meta[DIV_STAGES-1];
    assign o_quo  = r_quo[DIV_STAGES-1];

endmodule
`default_nettype wire

### src/hbf_out.sv
// back stages: force saturation, stress products and their saturation, result registers
// depends on hbf_pkg
`default_nettype none
module hbf_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  hbf_pkg::t_div                i_meta,
    input  logic [2:0][hbf_pkg::CW-1:0]  i_quo,
    output logic                         o_vld,
    output logic [2:0][hbf_pkg::CW-1:0]  o_force,
    output logic [8:0][hbf_pkg::CW-1:0]  o_stress
);
    import hbf_pkg::*;

    logic                  r_h_vld, r_i_vld, r_j_vld;
    logic [2:0][CW-1:0]    r_h_f, r_h_d, r_i_f, r_i_d, r_j_f;
    logic [8:0][SQW-1:0]   r_i_p;
    logic [8:0][CW-1:0]    r_j_s;
    logic [2:0][CW-1:0]    n_f;
    logic [8:0][SQW-1:0]   n_p;
    logic [8:0][CW-1:0]    n_s;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            // zero length gives zero force
            if (i_meta.len == '0) begin
                n_f[j] = '0;
            end else begin
                n_f[j] = f_pack(i_meta.ovf[j], i_quo[j], i_meta.eneg ^ i_meta.d[j][CW-1]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_p[3*j+i] = SQW'(f_mag(r_h_d[i])) * SQW'(f_mag(r_h_f[j]));
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_s[3*j+i] = f_pack(|r_i_p[3*j+i][SQW-1:FRAC_BITS+CW],
                                    r_i_p[3*j+i][FRAC_BITS+CW-1:FRAC_BITS],
                                    r_i_d[i][CW-1] ^ r_i_f[j][CW-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
        end else begin
            r_h_vld <= i_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
        end
        r_h_f <= n_f;
        r_h_d <= i_meta.d;
        r_i_f <= r_h_f;
        r_i_d <= r_h_d;
        r_i_p <= n_p;
        r_j_f <= r_i_f;
        r_j_s <= n_s;
    end

    assign o_vld    = r_j_vld;
    assign o_force  = r_j_f;
    assign o_stress = r_j_s;

endmodule
`default_nettype wire

### src/harmonic_bond_force_unit.sv
// top level of the harmonic bond force unit: config registers, force scaling stages
// depends on hbf_pkg, hbf_front, hbf_sqrt, hbf_div, hbf_out and the macros header
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  bond in  | start, busy          | i_head_*, i_tail_*, i_spring_constant, ...
//  result   | o_valid (strobe)     | o_force_*, o_stress_*
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one bond item can enter every cycle; busy is always low
// results pass the front stages, the root pipeline, the scaling stages, the divider and the
// back stages; the root and divider pipelines each resolve one bit per stage
// synchronous active-low reset clears the valid bits and loads the register defaults
// results are strobed for one cycle and cannot be held off
`default_nettype none
`include "harmonic_bond_force_unit_macros.svh"
module harmonic_bond_force_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hbf_pkg::CW-1:0]      i_head_x,
    input  logic [hbf_pkg::CW-1:0]      i_head_y,
    input  logic [hbf_pkg::CW-1:0]      i_head_z,
    input  logic [hbf_pkg::CW-1:0]      i_tail_x,
    input  logic [hbf_pkg::CW-1:0]      i_tail_y,
    input  logic [hbf_pkg::CW-1:0]      i_tail_z,
    input  logic [hbf_pkg::CW-2:0]      i_spring_constant,
    input  logic [hbf_pkg::CW-2:0]      i_rest_length,
    output logic                        o_valid,
    output logic [hbf_pkg::CW-1:0]      o_force_x,
    output logic [hbf_pkg::CW-1:0]      o_force_y,
    output logic [hbf_pkg::CW-1:0]      o_force_z,
    output logic [hbf_pkg::CW-1:0]      o_stress_xx,
    output logic [hbf_pkg::CW-1:0]      o_stress_yx,
    output logic [hbf_pkg::CW-1:0]      o_stress_zx,
    output logic [hbf_pkg::CW-1:0]      o_stress_xy,
    output logic [hbf_pkg::CW-1:0]      o_stress_yy,
    output logic [hbf_pkg::CW-1:0]      o_stress_zy,
    output logic [hbf_pkg::CW-1:0]      o_stress_xz,
    output logic [hbf_pkg::CW-1:0]      o_stress_yz,
    output logic [hbf_pkg::CW-1:0]      o_stress_zz,
    input  logic                        i_cfg_we,
    input  logic [hbf_pkg::IDXW-1:0]    i_cfg_idx,
    input  logic [hbf_pkg::CW-2:0]      i_cfg_data
);
    import hbf_pkg::*;

    localparam logic [CW-2:0] BOX_RESET = (CW-1)'(32) << FRAC_BITS;

    logic                r_periodic, r_three_d;
    logic [2:0][CW-2:0]  r_box;

    logic                fr_vld, sq_vld, dv_vld, out_vld;
    t_geo                fr_geo, sq_geo;
    logic [SQW-1:0]      fr_sum;
    logic [CW-1:0]       sq_len;

    logic                r_e_vld, r_f_vld, r_g_vld;
    t_geo                r_e_geo, r_f_geo;
    logic [CW-1:0]       r_e_len, r_f_len;
    logic                r_e_eneg, r_f_eneg;
    logic [SQW-1:0]      r_e_m;
    logic [2:0][SQW-1:0] r_f_pl, r_f_ph;
    t_div                r_g_meta, dv_meta;
    logic [2:0][CW-1:0]  r_g_rem, r_g_num, dv_quo;

    logic [CW:0]         n_e;
    logic [CW-1:0]       n_emag;
    logic [2:0][SQW-1:0] n_pl, n_ph;
    logic [2:0]          n_ovf;
    logic [2:0][CW-1:0]  n_rem, n_num;
    logic [2:0][CW-1:0]  out_force;
    logic [8:0][CW-1:0]  out_stress;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periodic <= 1'b1;
            r_three_d  <= 1'b1;
            r_box      <= {BOX_RESET, BOX_RESET, BOX_RESET};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PERIODIC: r_periodic <= i_cfg_data[0];
                REG_THREE_D:  r_three_d  <= i_cfg_data[0];
                REG_BOX_X:    r_box[0]   <= i_cfg_data;
                REG_BOX_Y:    r_box[1]   <= i_cfg_data;
                REG_BOX_Z:    r_box[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (start && !busy),
        .i_head     ({i_head_z, i_head_y, i_head_x}),
        .i_tail     ({i_tail_z, i_tail_y, i_tail_x}),
        .i_k        (i_spring_constant),
        .i_l0       (i_rest_length),
        .i_periodic (r_periodic),
        .i_three_d  (r_three_d),
        .i_box      (r_box),
        .o_vld      (fr_vld),
        .o_geo      (fr_geo),
        .o_sum      (fr_sum)
    );

    hbf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fr_vld),
        .i_geo   (fr_geo),
        .i_sum   (fr_sum),
        .o_vld   (sq_vld),
        .o_geo   (sq_geo),
        .o_len   (sq_len)
    );

    // stretch error and k*|l0-len|
    always_comb begin
        n_e    = {2'b00, sq_geo.l0} - {1'b0, sq_len};
        n_emag = n_e[CW] ? (~n_e[CW-1:0] + 1'b1) : n_e[CW-1:0];
    end

    // m*|d| as two partial products per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_pl[a] = SQW'(r_e_m[CW-1:0]) * SQW'(f_mag(r_e_geo.d[a]));
            n_ph[a] = SQW'(r_e_m[SQW-1:CW]) * SQW'(f_mag(r_e_geo.d[a]));
        end
    end

    // drop the fraction, flag quotients that cannot fit, seed the divider
    always_comb begin
        logic [PW-1:0] x;
        logic [YW-1:0] y;
        for (int a = 0; a < 3; a++) begin
            x        = {r_f_ph[a], {CW{1'b0}}} + PW'(r_f_pl[a]);
            y        = x[PW-1:FRAC_BITS];
            n_ovf[a] = y[YW-1:CW] >= (YW-CW)'(r_f_len);
            n_rem[a] = y[CW-1+CW:CW];
            n_num[a] = y[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_e_vld <= sq_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
        r_e_geo       <= sq_geo;
        r_e_len       <= sq_len;
        r_e_eneg      <= n_e[CW];
        r_e_m         <= SQW'({1'b0, sq_geo.k}) * SQW'(n_emag);
        r_f_geo       <= r_e_geo;
        r_f_len       <= r_e_len;
        r_f_eneg      <= r_e_eneg;
        r_f_pl        <= n_pl;
        r_f_ph        <= n_ph;
        r_g_meta.d    <= r_f_geo.d;
        r_g_meta.len  <= r_f_len;
        r_g_meta.eneg <= r_f_eneg;
        r_g_meta.ovf  <= n_ovf;
        r_g_rem       <= n_rem;
        r_g_num       <= n_num;
    end

    hbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_g_vld),
        .i_meta  (r_g_meta),
        .i_rem   (r_g_rem),
        .i_num   (r_g_num),
        .o_vld   (dv_vld),
        .o_meta  (dv_meta),
        .o_quo   (dv_quo)
    );

    hbf_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (dv_vld),
        .i_meta   (dv_meta),
        .i_quo    (dv_quo),
        .o_vld    (out_vld),
        .o_force  (out_force),
        .o_stress (out_stress)
    );

    assign o_valid     = out_vld;
    assign o_force_x   = out_force[0];
    assign o_force_y   = out_force[1];
    assign o_force_z   = out_force[2];
    assign o_stress_xx = out_stress[0];
    assign o_stress_yx = out_stress[1];
    assign o_stress_zx = out_stress[2];
    assign o_stress_xy = out_stress[3];
    assign o_stress_yy = out_stress[4];
    assign o_stress_zy = out_stress[5];
    assign o_stress_xz = out_stress[6];
    assign o_stress_yz = out_stress[7];
    assign o_stress_zz = out_stress[8];

    // a result strobe only ever follows an accepted item by the full latency
    `HBF_ASSERT_IMPLY(a_result_follows_item, i_clk, i_rst_n, o_valid, $past(start && !busy, LATENCY))
    // no force along x means no stress from it
    `HBF_ASSERT_IMPLY(a_zero_force_zero_stress, i_clk, i_rst_n, o_valid && o_force_x == '0, o_stress_xx == '0 && o_stress_yx == '0 && o_stress_zx == '0)
    // a strobe never comes unless the divider output was valid when that item entered the back stages
    `HBF_ASSERT_NEVER(a_valid_without_source, i_clk, i_rst_n, o_valid && !$past(dv_vld, 3))

endmodule
`default_nettype wire

### sim/harmonic_bond_force_unit_tb.sv
// self-checking testbench for the harmonic bond force unit
// depends on hbf_pkg and harmonic_bond_force_unit; bonds are predicted in place and checked in order
`default_nettype none
module harmonic_bond_force_unit_tb;
    import hbf_pkg::*;

    typedef struct packed {
        logic [CW-1:0] hx, hy, hz, tx, ty, tz;
        logic [CW-2:0] k, l0;
    } t_bond;

    typedef logic [11:0][CW-1:0] t_forces;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_bond         drv = '0;
    logic          o_valid;
    t_forces       got;
    logic          i_cfg_we = 1'b0;
    logic [IDXW-1:0] i_cfg_idx = '0;
    logic [CW-2:0] i_cfg_data = '0;

    // mirrored register set
    logic          m_periodic = 1'b1;
    logic          m_three_d = 1'b1;
    logic [CW-2:0] m_box [3] = '{31'd2097152, 31'd2097152, 31'd2097152};

    t_bond   bond_q [$];
    t_forces force_q [$];
    t_bond   cur;
    logic    cur_valid = 1'b0;
    logic    taken = 1'b0;
    logic    quiet = 1'b0;
    int      gap = 0;
    int      n_bonds = 0, n_results = 0, n_errs = 0, n_zero_len = 0;

    string names [12] = '{"force_x", "force_y", "force_z", "stress_xx", "stress_yx",
                          "stress_zx", "stress_xy", "stress_yy", "stress_zy", "stress_xz",
                          "stress_yz", "stress_zz"};

    harmonic_bond_force_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_head_x(drv.hx), .i_head_y(drv.hy), .i_head_z(drv.hz),
        .i_tail_x(drv.tx), .i_tail_y(drv.ty), .i_tail_z(drv.tz),
        .i_spring_constant(drv.k), .i_rest_length(drv.l0),
        .o_valid(o_valid),
        .o_force_x(got[0]), .o_force_y(got[1]), .o_force_z(got[2]),
        .o_stress_xx(got[3]), .o_stress_yx(got[4]), .o_stress_zx(got[5]),
        .o_stress_xy(got[6]), .o_stress_yy(got[7]), .o_stress_zy(got[8]),
        .o_stress_xz(got[9]), .o_stress_yz(got[10]), .o_stress_zz(got[11]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // saturate a magnitude with sign to a 32-bit pattern
    function automatic logic [CW-1:0] sat_signed(input logic [127:0] mag, input logic neg);
        logic [127:0] cap;
        logic [CW-1:0] v;
        cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        v = (mag > cap) ? cap[CW-1:0] : mag[CW-1:0];
        return neg ? (~v + 1'b1) : v;
    endfunction

    function automatic t_forces bond_forces(input t_bond b);
        longint        d [3];
        logic [63:0]   ad [3];
        logic [63:0]   bx;
        logic [65:0]   sum_sq;
        logic [33:0]   len, trial;
        logic [67:0]   sq;
        longint        e;
        logic          eneg;
        logic [127:0]  m, q;
        logic [63:0]   fm;
        t_forces       r;
        r = '0;
        d[0] = longint'(signed'(b.hx)) - longint'(signed'(b.tx));
        d[1] = longint'(signed'(b.hy)) - longint'(signed'(b.ty));
        d[2] = longint'(signed'(b.hz)) - longint'(signed'(b.tz));
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            bx = {33'd0, m_box[i]};
            if (m_periodic) begin
                if (i == 2 && !m_three_d)
                    d[i] = 0;
                else if (2 * d[i] > longint'(bx))
                    d[i] -= longint'(bx);
                else if (2 * d[i] < -longint'(bx))
                    d[i] += longint'(bx);
            end
            if (d[i] > 64'sh7FFF_FFFF) d[i] = 64'sh7FFF_FFFF;
            if (d[i] < -64'sh8000_0000) d[i] = -64'sh8000_0000;
            ad[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            sum_sq = sum_sq + 66'(ad[i]) * 66'(ad[i]);
        end
        len = '0;
        for (int i = 33; i >= 0; i--) begin
            trial = len | (34'd1 << i);
            sq = 68'(trial) * 68'(trial);
            if (sq <= 68'(sum_sq)) len = trial;
        end
        if (len == 0) return r;
        e = longint'(b.l0) - longint'(len);
        eneg = e < 0;
        m = 128'(eneg ? -e : e) * 128'(b.k);
        for (int j = 0; j < 3; j++) begin
            if (ad[j] != 0) begin
                q = (m * 128'(ad[j])) / 128'(len);
                r[j] = sat_signed(q >> FRAC_BITS, eneg != (d[j] < 0));
            end
        end
        for (int j = 0; j < 3; j++) begin
            fm = r[j][CW-1] ? 64'(-longint'(signed'(r[j]))) : 64'(r[j]);
            for (int i = 0; i < 3; i++)
                r[3 + 3 * j + i] = sat_signed((128'(ad[i]) * 128'(fm)) >> FRAC_BITS,
                                              (d[i] < 0) != r[j][CW-1]);
        end
        return r;
    endfunction

    // sender: one item per handshake, random idle bursts
    always @(negedge i_clk) begin
        if (taken) begin
            cur_valid = 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
        end
        if (gap > 0) begin
            gap--;
        end else if (!cur_valid && bond_q.size() > 0) begin
            cur = bond_q.pop_front();
            cur_valid = 1'b1;
        end
        start <= cur_valid;
        if (cur_valid) drv <= cur;
    end

    // monitor: predict on acceptance, check results in order, mirror register writes
    always @(posedge i_clk) begin
        t_forces exp_f;
        taken = i_rst_n && start && !busy;
        if (taken) begin
            force_q.push_back(bond_forces(drv));
            n_bonds++;
        end
        if (i_rst_n && o_valid) begin
            n_results++;
            if (force_q.size() == 0) begin
                $error("result with no bond outstanding");
                n_errs++;
            end else begin
                exp_f = force_q.pop_front();
                if (exp_f == '0) n_zero_len++;
                for (int i = 0; i < 12; i++)
                    if (got[i] !== exp_f[i]) begin
                        $error("%s: expected %h, got %h", names[i], exp_f[i], got[i]);
                        n_errs++;
                    end
            end
        end
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIODIC: m_periodic = i_cfg_data[0];
                REG_THREE_D:  m_three_d = i_cfg_data[0];
                REG_BOX_X:    m_box[0] = i_cfg_data;
                REG_BOX_Y:    m_box[1] = i_cfg_data;
                REG_BOX_Z:    m_box[2] = i_cfg_data;
                default: ;
            endcase
        end
    end

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CW-2:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_bond(input logic [CW-1:0] hx, hy, hz, tx, ty, tz,
                            input logic [CW-2:0] k, l0);
        bond_q.push_back('{hx, hy, hz, tx, ty, tz, k, l0});
    endtask

    function automatic t_bond random_bond();
        t_bond b;
        logic [CW-1:0] dl [3];
        int kind;
        kind = $urandom_range(0, 9);
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             31'($urandom), 31'($urandom)};
        if (kind >= 3) begin
            // physically sized bond: small separation, moderate spring
            b.tx = signed'(b.tx) >>> $urandom_range(0, 12);
            b.ty = signed'(b.ty) >>> $urandom_range(0, 12);
            b.tz = signed'(b.tz) >>> $urandom_range(0, 12);
            for (int i = 0; i < 3; i++) begin
                dl[i] = signed'(32'($urandom)) >>> $urandom_range(8, 24);
                if (kind == 8 && $urandom_range(0, 1)) dl[i] = '0;
                if (kind == 9)
                    dl[i] = (m_box[i] >> 1) + 32'($urandom_range(0, 2)) - 32'd1;
            end
            if (kind == 8 && $urandom_range(0, 2) == 0) dl = '{'0, '0, '0};
            b.hx = b.tx + dl[0];
            b.hy = b.ty + dl[1];
            b.hz = b.tz + dl[2];
            b.k  = b.k >> $urandom_range(6, 24);
            b.l0 = b.l0 >> $urandom_range(8, 24);
        end
        return b;
    endfunction

    task automatic run_bonds(input int n);
        for (int i = 0; i < n; i++) bond_q.push_back(random_bond());
        // hold off until every expected result is back
        while (bond_q.size() > 0 || cur_valid || force_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed bonds at reset settings, 32.0 box
        add_bond('0, '0, '0, '0, '0, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);          // zero length
        add_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, '0);
        add_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_bond(32'h0010_0000, '0, '0, '0, '0, '0, 31'h0001_0000, 31'h0001_0000);   // exactly half box
        add_bond(32'h0010_0001, '0, '0, '0, '0, '0, 31'h0001_0000, 31'h0001_0000);
        add_bond('0, 32'hFFF0_0000, '0, '0, '0, '0, 31'h0001_0000, 31'h0001_0000);
        add_bond('0, 32'hFFEF_FFFF, '0, '0, '0, '0, 31'h0001_0000, 31'h0001_0000);
        add_bond(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, '0, '0, '0, '0, 31'h0001_0000);
        add_bond(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, '0, '0, '0, 31'h0004_0000, '0);
        add_bond(32'h0000_8000, '0, '0, 32'h0000_8000, 32'h0000_0001, '0,
                 31'h0010_0000, 31'h0002_0000);
        add_bond(32'h0000_0003, 32'h0000_0004, '0, '0, '0, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_bond(32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0, 31'h0001_0000, 31'h0005_0000);
        add_bond(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_bonds(290);

        write_reg(REG_PERIODIC, 31'h0);                 // absolute coordinates
        write_reg(REG_THREE_D, 31'h1);
        run_bonds(240);

        write_reg(REG_PERIODIC, 31'h7FFF_FFFF);         // upper bits ignored
        write_reg(REG_THREE_D, 31'h7FFF_FFFE);          // two-dimensional
        for (int i = 0; i < 3; i++)
            write_reg(IDXW'(REG_BOX_X) + IDXW'(i), 31'($urandom_range(1, 32'h0100_0000)));
        run_bonds(240);

        write_reg(REG_THREE_D, 31'h1);
        write_reg(REG_BOX_X, 31'h0);                    // zero box leaves x unwrapped
        write_reg(REG_BOX_Y, 31'h7FFF_FFFF);
        write_reg(REG_BOX_Z, 31'h1);
        write_reg(IDXW'($urandom_range(5, 7)), 31'($urandom));   // unknown index, ignored
        run_bonds(240);

        write_reg(REG_PERIODIC, 31'h0);
        write_reg(REG_THREE_D, 31'h0);                  // dz still kept without wrapping
        run_bonds(150);

        write_reg(REG_PERIODIC, 31'h1);
        write_reg(REG_THREE_D, 31'h1);
        for (int i = 0; i < 3; i++)
            write_reg(IDXW'(REG_BOX_X) + IDXW'(i), 31'($urandom) >> $urandom_range(0, 16));
        quiet = 1'b1;
        run_bonds(270);

        $display("bonds sent %0d, results checked %0d (%0d all zero), periodic/2d/3d and",
                 n_bonds, n_results, n_zero_len);
        $display("box extremes including zero and full scale covered");
        if (n_errs == 0 && force_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
